FILE: rtl/core/ctif_pkg.sv
// shared types and constants for the calibration table interpolate/fill core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctif_pkg;

    localparam int CHANNELS_DEF = 8192;
    localparam int UNITS_DEF    = 2;

    localparam int CODE_W = 16;
    localparam int BASE_W = 14;
    localparam int FMHZ_W = 15;
    localparam int FHZ_W  = 34;

    // divider sized for interpolation numerators; also holds hz plus half a mhz
    localparam int DIV_NW = 35;
    localparam int DIV_DW = 20;

    localparam logic [DIV_NW-1:0] HALF_MHZ = DIV_NW'(500000);

    // (hz + half) / 1e6 = ((hz + half) >> 6) / 15625, the last by reciprocal multiply,
    // exact for every 29-bit operand
    localparam int LK_MW  = DIV_NW - 6;
    localparam int LK_RW  = 30;
    localparam int LK_PW  = LK_MW + LK_RW;
    localparam int LK_RSH = 43;
    localparam logic [LK_RW-1:0] LK_RECIP = LK_RW'(562949954);

    typedef enum logic [1:0] {
        FN_WRITE  = 2'd0,
        FN_FILL   = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LK_MUL,
        ST_LK_RD,
        ST_LK_DATA,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PT_GO,
        ST_PT_NUM,
        ST_PT_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     known;
        logic signed [CODE_W-1:0] i_code;
        logic signed [CODE_W-1:0] q_code;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/core/ctif_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on ctif_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctif_div
    import ctif_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_dividend,
    input  wire logic [DIV_DW-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIV_NW-1:0]      o_quo
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DIV_NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? DIV_DW'(trial - {1'b0, r_dvs}) : DIV_DW'(trial);
            r_quo <= {r_quo[DIV_NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

FILE: rtl/core/ctif_num.sv
// two-stage numerator pipeline: y1*dx + (y2-y1)*(x-x1) for I and Q
// depends on ctif_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctif_num
    import ctif_pkg::*;
#(
    parameter int IW = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [IW-1:0]            i_x1,
    input  wire logic [IW-1:0]            i_x2,
    input  wire logic [IW-1:0]            i_x,
    input  wire t_entry                   i_p1,
    input  wire t_entry                   i_p2,
    output logic                          o_done,
    output logic [IW-1:0]                 o_dx,
    output logic                          o_neg_i,
    output logic                          o_neg_q,
    output logic [IW+18:0]                o_mag_i,
    output logic [IW+18:0]                o_mag_q
);

    localparam int PW = IW + 19;

    logic                 r_v1, r_v2;
    logic [IW-1:0]        r_dx;
    logic signed [PW-1:0] r_a_i, r_b_i, r_a_q, r_b_q;
    logic signed [IW:0]   dx_s, dxk;
    logic signed [16:0]   dy_i, dy_q;
    logic signed [PW-1:0] sum_i, sum_q;
    logic                 r_neg_i, r_neg_q;
    logic [PW-1:0]        r_mag_i, r_mag_q;

    assign dx_s  = $signed({1'b0, IW'(i_x2 - i_x1)});
    assign dxk   = $signed({1'b0, i_x}) - $signed({1'b0, i_x1});
    assign dy_i  = 17'(i_p2.i_code) - 17'(i_p1.i_code);
    assign dy_q  = 17'(i_p2.q_code) - 17'(i_p1.q_code);
    assign sum_i = r_a_i + r_b_i;
    assign sum_q = r_a_q + r_b_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx  <= IW'(i_x2 - i_x1);
            r_a_i <= PW'(i_p1.i_code * dx_s);
            r_a_q <= PW'(i_p1.q_code * dx_s);
            r_b_i <= PW'(dy_i * dxk);
            r_b_q <= PW'(dy_q * dxk);
        end
        if (r_v1) begin
            r_neg_i <= sum_i < 0;
            r_neg_q <= sum_q < 0;
            r_mag_i <= (sum_i < 0) ? PW'(-sum_i) : PW'(sum_i);
            r_mag_q <= (sum_q < 0) ? PW'(-sum_q) : PW'(sum_q);
        end
    end

    assign o_done  = r_v2;
    assign o_dx    = r_dx;
    assign o_neg_i = r_neg_i;
    assign o_neg_q = r_neg_q;
    assign o_mag_i = r_mag_i;
    assign o_mag_q = r_mag_q;

endmodule

`default_nettype wire

FILE: rtl/core/ctif_table.sv
// calibration table memory, one write port and one registered read port
// depends on ctif_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctif_table
    import ctif_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/cal_table_interpolate_fill_core.sv
// top level: sequencer for write, fill, lookup and clear on the calibration table
// depends on ctif_pkg, ctif_table, ctif_num, ctif_div
//
// Usage
//   Input channel i_in_valid/o_in_ready carries one command word: i_func selects
//   write point, fill unit, lookup or clear table. Every accepted word yields one
//   result word on o_out_valid/i_out_ready (codes, known flag, range error).
//   i_cfg_we/i_cfg_data set base_mhz; write it only while the core is idle.
//   Work per word, from accept to result valid:
//     write       table write, skipped when out of range
//     lookup      reciprocal multiply, index, table read; no table read out of range
//     clear       zero the whole table (one entry per cycle)
//     fill        read and check each entry of the unit in turn; each entry filled
//                 passes the numerator pipeline and the divider; then the result
//   One word is in work at a time; the next word is taken the cycle after the
//   result is loaded into the output register. A stalled receiver holds the
//   result and the core waits before loading the next one.
//   After reset the core sweeps every table entry to zero with o_in_ready low;
//   configuration writes are taken during that sweep.
`timescale 1ns / 1ps
`default_nettype none

module cal_table_interpolate_fill_core
    import ctif_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int UNITS    = UNITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [BASE_W-1:0]        i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_func,
    input  wire logic                     i_unit,
    input  wire logic [FMHZ_W-1:0]        i_freq_mhz,
    input  wire logic [FHZ_W-1:0]         i_freq_hz,
    input  wire logic signed [CODE_W-1:0] i_in_i,
    input  wire logic signed [CODE_W-1:0] i_in_q,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [CODE_W-1:0]      o_out_i,
    output logic signed [CODE_W-1:0]      o_out_q,
    output logic                          o_known,
    output logic                          o_range_error
);

    localparam int IW    = (CHANNELS > 2) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * UNITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = IW + 19;
    localparam logic [IW-1:0] LAST = IW'(CHANNELS - 1);

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] idx, input logic u);
        addr_of = AW'(AW'(idx) * AW'(UNITS) + AW'(u));
    endfunction

    function automatic logic signed [CODE_W-1:0] sat_code(input logic neg,
                                                          input logic [DIV_NW-1:0] q);
        logic [16:0] mag;
        mag = 17'(q[15:0]);
        if (neg) begin
            if (q > DIV_NW'(32768)) sat_code = 16'sh8000;
            else                    sat_code = CODE_W'(-$signed(mag));
        end else begin
            if (q > DIV_NW'(32767)) sat_code = 16'sh7fff;
            else                    sat_code = q[15:0];
        end
    endfunction

    t_state r_state, n_state;

    logic [BASE_W-1:0]        r_base;
    logic                     r_unit;
    logic [AW-1:0]            r_clr_addr;
    logic                     r_clr_op;
    logic [IW-1:0]            r_j, r_k, r_x1, r_x2, r_lo;
    logic                     r_have_first;
    t_entry                   r_y1, r_y2;
    logic signed [CODE_W-1:0] r_res_i, r_res_q;
    logic                     r_res_known, r_res_err;
    logic                     r_out_valid;
    logic signed [CODE_W-1:0] r_out_i, r_out_q;
    logic                     r_out_known, r_out_err;
    logic [LK_MW-1:0]         r_lk_m;
    logic [FMHZ_W-1:0]        r_lk_q;

    logic            accept, unit_ok, wr_ok, lk_ok, out_free, seg_last;
    logic signed [16:0] wr_idx, lk_idx;
    logic [DIV_NW-1:0] lk_sum;
    logic [LK_PW-1:0]  lk_prod;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    t_entry          mem_wdata, rd;

    logic              num_start, num_done, neg_i, neg_q;
    logic [IW-1:0]     num_dx;
    logic [PW-1:0]     mag_i, mag_q;
    logic              div_start, div_i_done, div_q_done, div_done;
    logic [DIV_NW-1:0] quo_i, quo_q;

    assign accept   = i_in_valid && o_in_ready;
    assign unit_ok  = 32'(i_unit) < 32'(UNITS);
    assign wr_idx   = $signed({2'b0, i_freq_mhz}) - $signed({3'b0, r_base});
    assign wr_ok    = (wr_idx >= 0) && (wr_idx < $signed(17'(CHANNELS)));
    assign lk_sum   = DIV_NW'(i_freq_hz) + HALF_MHZ;
    assign lk_prod  = LK_PW'(r_lk_m) * LK_PW'(LK_RECIP);
    assign lk_idx   = $signed({2'b0, r_lk_q}) - $signed({3'b0, r_base});
    assign lk_ok    = (lk_idx >= 0) && (lk_idx < $signed(17'(CHANNELS)));
    assign out_free = !r_out_valid || i_out_ready;
    assign seg_last = IW'(r_k + IW'(1)) == r_x2;
    assign div_done = div_i_done && div_q_done;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = r_clr_op ? ST_DONE : ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_func'(i_func))
                        FN_WRITE:  n_state = ST_DONE;
                        FN_FILL:   n_state = unit_ok ? ST_SCAN_RD : ST_DONE;
                        FN_LOOKUP: n_state = unit_ok ? ST_LK_MUL : ST_DONE;
                        FN_CLEAR:  n_state = ST_CLEAR;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_LK_MUL: n_state = ST_LK_RD;
            ST_LK_RD:  n_state = lk_ok ? ST_LK_DATA : ST_DONE;
            ST_LK_DATA: n_state = ST_DONE;
            ST_SCAN_RD: n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (rd.known && r_have_first && (r_lo != r_j)) n_state = ST_PT_GO;
                else if (r_j == LAST)                          n_state = ST_DONE;
                else                                           n_state = ST_SCAN_RD;
            end
            ST_PT_GO: n_state = ST_PT_NUM;
            ST_PT_NUM: begin
                if (num_done) n_state = ST_PT_DIV;
            end
            ST_PT_DIV: begin
                if (div_done) begin
                    if (!seg_last)         n_state = ST_PT_GO;
                    else if (r_j == LAST)  n_state = ST_DONE;
                    else                   n_state = ST_SCAN_RD;
                end
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = addr_of(r_k, r_unit);
        mem_wdata   = '{known: 1'b1, i_code: sat_code(neg_i, quo_i),
                        q_code: sat_code(neg_q, quo_q)};
        mem_raddr   = addr_of(r_j, r_unit);
        num_start   = 1'b0;
        div_start   = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept && t_func'(i_func) == FN_WRITE && unit_ok && wr_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(wr_idx[IW-1:0], i_unit);
                    mem_wdata = '{known: 1'b1, i_code: i_in_i, q_code: i_in_q};
                end
            end
            ST_LK_RD:  mem_raddr = addr_of(lk_idx[IW-1:0], r_unit);
            ST_PT_GO:  num_start = 1'b1;
            ST_PT_NUM: div_start = num_done;
            ST_PT_DIV: mem_we = div_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_base       <= '0;
            r_clr_addr   <= '0;
            r_clr_op     <= 1'b0;
            r_have_first <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_base <= i_cfg_data;
            if (r_state == ST_CLEAR) r_clr_addr <= AW'(r_clr_addr + AW'(1));
            if (r_state == ST_IDLE && accept) begin
                r_clr_op   <= t_func'(i_func) == FN_CLEAR;
                r_clr_addr <= '0;
                r_have_first <= 1'b0;
            end
            if (r_state == ST_SCAN_CHK && rd.known && !r_have_first) r_have_first <= 1'b1;
            if (r_state == ST_DONE && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready)               r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_unit      <= i_unit;
                r_j         <= '0;
                r_lk_m      <= lk_sum[DIV_NW-1:DIV_NW-LK_MW];
                r_res_i     <= '0;
                r_res_q     <= '0;
                r_res_known <= 1'b0;
                r_res_err   <= ((t_func'(i_func) == FN_WRITE) && !(unit_ok && wr_ok))
                            || ((t_func'(i_func) != FN_CLEAR) && !unit_ok);
            end
            ST_LK_MUL: begin
                r_lk_q <= lk_prod[LK_RSH +: FMHZ_W];
            end
            ST_LK_RD: begin
                if (!lk_ok) r_res_err <= 1'b1;
            end
            ST_LK_DATA: begin
                r_res_i     <= rd.i_code;
                r_res_q     <= rd.q_code;
                r_res_known <= rd.known;
            end
            ST_SCAN_CHK: begin
                if (rd.known && !r_have_first) begin
                    r_x1 <= r_j;
                    r_y1 <= rd;
                    r_lo <= '0;
                end else if (rd.known && r_lo == r_j) begin
                    // neighbouring known points, nothing between them
                    r_x1 <= r_j;
                    r_y1 <= rd;
                    r_lo <= IW'(r_j + IW'(1));
                end else if (rd.known) begin
                    r_x2 <= r_j;
                    r_y2 <= rd;
                    r_k  <= r_lo;
                end
                if (!(rd.known && r_have_first && r_lo != r_j)) r_j <= IW'(r_j + IW'(1));
            end
            ST_PT_DIV: begin
                if (div_done) begin
                    r_k <= IW'(r_k + IW'(1));
                    if (seg_last) begin
                        r_x1 <= r_x2;
                        r_y1 <= r_y2;
                        r_lo <= IW'(r_x2 + IW'(1));
                        r_j  <= IW'(r_j + IW'(1));
                    end
                end
            end
            default: ;
        endcase
        if (r_state == ST_DONE && out_free) begin
            r_out_i     <= r_res_i;
            r_out_q     <= r_res_q;
            r_out_known <= r_res_known;
            r_out_err   <= r_res_err;
        end
    end

    ctif_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    ctif_num #(
        .IW (IW)
    ) u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (num_start),
        .i_x1    (r_x1),
        .i_x2    (r_x2),
        .i_x     (r_k),
        .i_p1    (r_y1),
        .i_p2    (r_y2),
        .o_done  (num_done),
        .o_dx    (num_dx),
        .o_neg_i (neg_i),
        .o_neg_q (neg_q),
        .o_mag_i (mag_i),
        .o_mag_q (mag_q)
    );

    ctif_div u_div_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIV_NW'(mag_i)),
        .i_divisor  (DIV_DW'(num_dx)),
        .o_done     (div_i_done),
        .o_quo      (quo_i)
    );

    ctif_div u_div_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIV_NW'(mag_q)),
        .i_divisor  (DIV_DW'(num_dx)),
        .o_done     (div_q_done),
        .o_quo      (quo_q)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_i       = r_out_i;
    assign o_out_q       = r_out_q;
    assign o_known       = r_out_known;
    assign o_range_error = r_out_err;

endmodule

`default_nettype wire

FILE: rtl/core/ctif_checker.sv
// port-level checks for the calibration table core, bound to the top level
// depends on ctif_pkg and cal_table_interpolate_fill_core
`timescale 1ns / 1ps
`default_nettype none

module ctif_checker
    import ctif_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_ready,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic signed [CODE_W-1:0] o_out_i,
    input wire logic signed [CODE_W-1:0] o_out_q,
    input wire logic                     o_known,
    input wire logic                     o_range_error
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_i)
            && $stable(o_out_q) && $stable(o_known) && $stable(o_range_error))
        else $error("result word changed while stalled");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // results without the known flag (entries never written or filled, range errors) carry zero codes
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_known |-> o_out_i == '0 && o_out_q == '0)
        else $error("unknown entry returned nonzero codes");

    a_err_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> !o_known)
        else $error("range error with known entry");

    // one word in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready straight after an accepted word");

endmodule

bind cal_table_interpolate_fill_core ctif_checker u_ctif_checker (.*);

`default_nettype wire

FILE: tb/cal_table_interpolate_fill_core_check.sv
// checker for the calibration table core: keeps its own copy of the table,
// predicts each result word and compares it with what the core returns
// depends on ctif_pkg
`timescale 1ns / 1ps

module cal_table_interpolate_fill_core_check
    import ctif_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int UNITS    = UNITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [BASE_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [1:0]               i_func,
    input  logic                     i_unit,
    input  logic [FMHZ_W-1:0]        i_freq_mhz,
    input  logic [FHZ_W-1:0]         i_freq_hz,
    input  logic signed [CODE_W-1:0] i_in_i,
    input  logic signed [CODE_W-1:0] i_in_q,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [CODE_W-1:0] i_out_i,
    input  logic signed [CODE_W-1:0] i_out_q,
    input  logic                     i_known,
    input  logic                     i_range_error,
    output int                       o_errors,
    output int                       o_pending
);

    localparam int DEPTH = CHANNELS * UNITS;

    typedef struct {
        logic signed [CODE_W-1:0] out_i;
        logic signed [CODE_W-1:0] out_q;
        logic                     known;
        logic                     range_error;
    } t_result;

    logic signed [CODE_W-1:0] tab_i [0:DEPTH-1];
    logic signed [CODE_W-1:0] tab_q [0:DEPTH-1];
    logic                     tab_known [0:DEPTH-1];
    logic [BASE_W-1:0]        base_mhz;
    t_result                  results_due [$];

    assign o_pending = results_due.size();

    function automatic logic signed [CODE_W-1:0] line_at(longint x1, longint y1, longint x2,
                                                          longint y2, longint x);
        longint v;
        v = (y1 * (x2 - x1) + (y2 - y1) * (x - x1)) / (x2 - x1);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return CODE_W'(v);
    endfunction

    function automatic void put_point(int dst, int a, int b, int u);
        int d, pa, pb;
        d  = dst * UNITS + u;
        pa = a * UNITS + u;
        pb = b * UNITS + u;
        tab_i[d] = line_at(a, tab_i[pa], b, tab_i[pb], dst);
        tab_q[d] = line_at(a, tab_q[pa], b, tab_q[pb], dst);
        tab_known[d] = 1'b1;
    endfunction

    function automatic void fill_column(int u);
        int first, second, prev;
        first = -1;
        second = -1;
        for (int j = 0; j < CHANNELS; j++) begin
            if (tab_known[j * UNITS + u]) begin
                if (first < 0) first = j;
                else if (second < 0) second = j;
            end
        end
        if (second < 0) return;
        for (int j = 0; j < first; j++) put_point(j, first, second, u);
        prev = first;
        for (int j = first + 1; j < CHANNELS; j++) begin
            if (tab_known[j * UNITS + u]) begin
                for (int k = prev + 1; k < j; k++) put_point(k, prev, j, u);
                prev = j;
            end
        end
    endfunction

    function automatic void wipe_table();
        for (int n = 0; n < DEPTH; n++) begin
            tab_i[n] = '0;
            tab_q[n] = '0;
            tab_known[n] = 1'b0;
        end
    endfunction

    function automatic t_result predict_word();
        t_result r;
        longint  idx;
        int      p;
        r = '{default: '0};
        case (t_func'(i_func))
            FN_WRITE: begin
                idx = longint'(i_freq_mhz) - longint'(base_mhz);
                if (int'(i_unit) >= UNITS || idx < 0 || idx >= CHANNELS) begin
                    r.range_error = 1'b1;
                end else begin
                    p = int'(idx) * UNITS + int'(i_unit);
                    tab_i[p] = i_in_i;
                    tab_q[p] = i_in_q;
                    tab_known[p] = 1'b1;
                end
            end
            FN_FILL: begin
                if (int'(i_unit) >= UNITS) r.range_error = 1'b1;
                else fill_column(int'(i_unit));
            end
            FN_LOOKUP: begin
                idx = (longint'(i_freq_hz) + 500000) / 1000000 - longint'(base_mhz);
                if (int'(i_unit) >= UNITS || idx < 0 || idx >= CHANNELS) begin
                    r.range_error = 1'b1;
                end else begin
                    p = int'(idx) * UNITS + int'(i_unit);
                    r.out_i = tab_i[p];
                    r.out_q = tab_q[p];
                    r.known = tab_known[p];
                end
            end
            default: wipe_table();
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            wipe_table();
            base_mhz <= '0;
            o_errors = 0;
        end else begin
            if (i_cfg_we) base_mhz <= i_cfg_data;
            if (i_in_valid && i_in_ready) results_due.push_back(predict_word());
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with nothing expected");
                    o_errors++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out_i !== want.out_i) begin
                        $error("out_i: expected %0d, got %0d", want.out_i, i_out_i);
                        o_errors++;
                    end
                    if (i_out_q !== want.out_q) begin
                        $error("out_q: expected %0d, got %0d", want.out_q, i_out_q);
                        o_errors++;
                    end
                    if (i_known !== want.known) begin
                        $error("known: expected %0b, got %0b", want.known, i_known);
                        o_errors++;
                    end
                    if (i_range_error !== want.range_error) begin
                        $error("range_error: expected %0b, got %0b", want.range_error,
                               i_range_error);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/cal_table_interpolate_fill_core_test.sv
// testbench top for the calibration table core: clock, reset, base register
// writes, command words and the verdict; depends on ctif_pkg, the core and the checker
`timescale 1ns / 1ps

module cal_table_interpolate_fill_core_test;
    import ctif_pkg::*;

    localparam int CHANNELS   = 8192;
    localparam int UNITS      = 2;
    localparam int STALL_LIMIT = 200000;
    localparam longint MHZ    = 1000000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [BASE_W-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_func = FN_LOOKUP;
    logic                     i_unit = 1'b0;
    logic [FMHZ_W-1:0]        i_freq_mhz = '0;
    logic [FHZ_W-1:0]         i_freq_hz = '0;
    logic signed [CODE_W-1:0] i_in_i = '0;
    logic signed [CODE_W-1:0] i_in_q = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [CODE_W-1:0] o_out_i;
    logic signed [CODE_W-1:0] o_out_q;
    logic                     o_known;
    logic                     o_range_error;

    int          errors;
    int          pending;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;
    int          words_sent = 0;
    int          fills_sent = 0;
    int          clears_sent = 0;
    logic [BASE_W-1:0] base;

    cal_table_interpolate_fill_core #(.CHANNELS(CHANNELS), .UNITS(UNITS)) dut (.*);

    cal_table_interpolate_fill_core_check #(.CHANNELS(CHANNELS), .UNITS(UNITS)) checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready),
        .i_func, .i_unit, .i_freq_mhz, .i_freq_hz, .i_in_i, .i_in_q,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_i(o_out_i), .i_out_q(o_out_q),
        .i_known(o_known), .i_range_error(o_range_error),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= 22);
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("cal_table_interpolate_fill_core_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(t_func fn, logic u, logic [FMHZ_W-1:0] fmhz,
                             logic [FHZ_W-1:0] fhz, logic [15:0] vi, logic [15:0] vq);
        int  gap;
        logic rdy;
        gap = (!no_idle && $urandom_range(99) < 22) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_unit     <= u;
        i_freq_mhz <= fmhz;
        i_freq_hz  <= fhz;
        i_in_i     <= vi;
        i_in_q     <= vq;
        do begin
            @(negedge i_clk);
            rdy = o_in_ready;
            @(posedge i_clk);
        end while (!rdy);
        words_sent++;
        if (fn == FN_FILL) fills_sent++;
        if (fn == FN_CLEAR) clears_sent++;
    endtask

    task automatic settle_and_set_base(logic [BASE_W-1:0] b);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        base = b;
    endtask

    function automatic logic [FHZ_W-1:0] hz_of(longint mhz_val);
        return FHZ_W'(mhz_val * MHZ);
    endfunction

    task automatic random_word();
        int          r;
        logic [FMHZ_W-1:0] fm;
        logic [FHZ_W-1:0]  fh;
        r = $urandom_range(999);
        if (r < 400) begin
            if ($urandom_range(9) == 0) begin
                fm = FMHZ_W'($urandom);
                // far in-range points would make every fill crawl; keep them near entry zero
                if (fm >= base && int'(fm) < int'(base) + CHANNELS)
                    fm = FMHZ_W'(int'(base) + int'(fm) % 46);
            end else begin
                fm = FMHZ_W'(int'(base) + $urandom_range(0, 40));
            end
            send_word(FN_WRITE, 1'($urandom), fm, FHZ_W'({$urandom, $urandom}),
                      16'($urandom), 16'($urandom));
        end else if (r < 415) begin
            send_word(FN_FILL, 1'($urandom), FMHZ_W'($urandom),
                      FHZ_W'({$urandom, $urandom}), 16'($urandom), 16'($urandom));
        end else if (r < 418) begin
            send_word(FN_CLEAR, 1'($urandom), FMHZ_W'($urandom),
                      FHZ_W'({$urandom, $urandom}), 16'($urandom), 16'($urandom));
        end else begin
            if ($urandom_range(99) < 15) fh = FHZ_W'({$urandom, $urandom});
            else fh = FHZ_W'(hz_of(longint'(base) + $urandom_range(0, 45)) - 500000
                             + $urandom_range(0, 999999));
            send_word(FN_LOOKUP, 1'($urandom), FMHZ_W'($urandom), fh,
                      16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [BASE_W-1:0] phase_base [6];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle_and_set_base(14'd100);

        // directed: empty table, range edges, saturation, interpolation, clear
        send_word(FN_LOOKUP, 1'b0, '0, hz_of(100), '0, '0);
        send_word(FN_LOOKUP, 1'b0, '0, '0, '0, '0);
        send_word(FN_LOOKUP, 1'b1, '0, '1, '0, '0);
        send_word(FN_WRITE, 1'b0, 15'd99, '0, 16'sd1, 16'sd1);
        send_word(FN_WRITE, 1'b0, 15'd32767, '0, 16'sd1, 16'sd1);
        send_word(FN_WRITE, 1'b1, 15'(100 + CHANNELS - 1), '0, 16'sh7FFF, 16'sh8000);
        send_word(FN_LOOKUP, 1'b1, '0, hz_of(100 + CHANNELS - 1) - 500000, '0, '0);
        send_word(FN_LOOKUP, 1'b1, '0, hz_of(100 + CHANNELS) - 500000, '0, '0);
        send_word(FN_FILL, 1'b0, '0, '0, '0, '0);
        send_word(FN_WRITE, 1'b0, 15'd120, '0, 16'sh8000, 16'sh7FFF);
        send_word(FN_FILL, 1'b0, '0, '0, '0, '0);
        send_word(FN_WRITE, 1'b0, 15'd121, '0, 16'sh7FFF, 16'sh8000);
        send_word(FN_FILL, 1'b0, '0, '0, '0, '0);
        send_word(FN_LOOKUP, 1'b0, '0, hz_of(100) + 499999, '0, '0);
        send_word(FN_LOOKUP, 1'b0, '0, hz_of(110), '0, '0);
        send_word(FN_WRITE, 1'b0, 15'd130, '0, 16'sd5, -16'sd7);
        send_word(FN_WRITE, 1'b0, 15'd140, '0, -16'sd3, 16'sd100);
        send_word(FN_FILL, 1'b1, '0, '0, '0, '0);
        send_word(FN_FILL, 1'b0, '0, '0, '0, '0);
        send_word(FN_LOOKUP, 1'b0, '0, hz_of(135) - 500000, '0, '0);
        send_word(FN_LOOKUP, 1'b0, '0, hz_of(125), '0, '0);
        send_word(FN_LOOKUP, 1'b0, '0, hz_of(141), '0, '0);
        send_word(FN_CLEAR, 1'b0, '0, '0, '0, '0);
        send_word(FN_LOOKUP, 1'b0, '0, hz_of(135), '0, '0);

        phase_base[0] = '0;
        phase_base[5] = '1;
        for (int ph = 1; ph < 5; ph++) phase_base[ph] = BASE_W'($urandom);
        for (int ph = 0; ph < 6; ph++) begin
            settle_and_set_base(phase_base[ph]);
            no_idle = (ph == 2);
            if (ph > 0) send_word(FN_CLEAR, 1'b0, '0, '0, '0, '0);
            for (int n = 0; n < 320; n++) random_word();
        end
        no_idle = 1'b0;

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d words: %0d fills, %0d clears, six base settings",
                 words_sent, fills_sent, clears_sent);
        $display("base settings ran from zero to all ones with random ones between");
        if (errors == 0) begin
            $display("cal_table_interpolate_fill_core_test: PASS");
        end else begin
            $display("cal_table_interpolate_fill_core_test: FAIL");
        end
        $finish;
    end

endmodule
